@@ src/cubic_newton_root_finder_top_assert.svh @@
// assertion macros of the root finder top module
`ifndef CUBIC_NEWTON_ROOT_FINDER_TOP_ASSERT_SVH
`define CUBIC_NEWTON_ROOT_FINDER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CNR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnr assertion failed");

// next-cycle implication, disabled in reset
`define CNR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnr assertion failed");

`endif

@@ src/cnr_pkg.sv @@
// shared constants, types and saturation helper of the cubic root finder
package cnr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int COEFF_W       = 16;
  localparam int TOL_W         = 16;
  localparam int ITER_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_CONVERGED  = 2'd0;
  localparam status_t ST_ZERO_DERIV = 2'd1;
  localparam status_t ST_CAP        = 2'd2;

  localparam cfg_idx_t REG_CUBE     = 3'd0;
  localparam cfg_idx_t REG_SQUARE   = 3'd1;
  localparam cfg_idx_t REG_LINEAR   = 3'd2;
  localparam cfg_idx_t REG_CONST    = 3'd3;
  localparam cfg_idx_t REG_TOL      = 3'd4;
  localparam cfg_idx_t REG_MAX_ITER = 3'd5;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-WORD_W:0] hi;
    hi = v[PROD_W-1:WORD_W-1];
    if (hi == '0 || hi == '1) begin
      sat_word = v[WORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ src/cnr_mac.sv @@
// shared multiply-accumulate unit with rounded and saturated outputs
module cnr_mac #(
  parameter int FRAC_BITS = cnr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  cnr_pkg::mac_ctl_t                   ctl,
  input  logic signed [cnr_pkg::WORD_W-1:0]   op_a,
  input  logic signed [cnr_pkg::WORD_W-1:0]   op_b,
  output logic signed [cnr_pkg::WORD_W-1:0]   rnd,
  output logic signed [cnr_pkg::WORD_W-1:0]   acc_sat
);
  import cnr_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] rnd_full;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.acc_en) begin
      acc_r <= (ctl.acc_clr ? '0 : acc_r) + prod_r;
    end
  end

  // round half up, floor shift
  assign rnd_full = (prod_r + HALF) >>> FRAC_BITS;
  assign rnd      = sat_word(rnd_full);
  assign acc_sat  = sat_word(acc_r);

endmodule

@@ src/cnr_div.sv @@
// serial restoring divider, one quotient bit per cycle, truncating toward zero
module cnr_div #(
  parameter int FRAC_BITS = cnr_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic signed [cnr_pkg::WORD_W-1:0]          num,
  input  logic signed [cnr_pkg::WORD_W-1:0]          den,
  output logic                                       done,
  output logic signed [cnr_pkg::WORD_W+FRAC_BITS:0]  quo
);
  import cnr_pkg::*;

  localparam int DW    = WORD_W + FRAC_BITS;
  localparam int QUO_W = DW + 1;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] rem_nxt;
  logic [DW-1:0]    nd_r;
  logic [WORD_W-1:0] den_r;
  logic             neg_r;
  logic [WORD_W-1:0] num_mag;
  logic [WORD_W-1:0] den_mag;
  logic [WORD_W:0]  trial;
  logic [WORD_W:0]  diff;
  logic             ge;
  logic [QUO_W-1:0] mag;

  assign num_mag = num[WORD_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[WORD_W-1] ? (~den + 1'b1) : den;

  assign trial   = {rem_r, nd_r[DW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nd_r  <= {num_mag, {FRAC_BITS{1'b0}}};
      den_r <= den_mag;
      neg_r <= num[WORD_W-1] ^ den[WORD_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nd_r  <= {nd_r[DW-2:0], ge};
    end
  end

  assign mag  = {1'b0, nd_r};
  assign quo  = neg_r ? (~mag + 1'b1) : mag;
  assign done = done_r;

endmodule

@@ src/cubic_newton_root_finder_top.sv @@
// cubic newton root finder: registers, sequencer and step update
// each step: nine multiply-accumulate micro-ops, each a multiply state then an accumulate state, then a divider pass
// the serial divider (one quotient bit a cycle) and the shared multiplier set the run time
// one item at a time: the next input transfer can be taken, at the earliest, the cycle after the result transfer
// reset (synchronous, rst_n low): sequencer idle, configuration registers to their defaults, no clearing pass
`include "cubic_newton_root_finder_top_assert.svh"

module cubic_newton_root_finder_top #(
  parameter int FRAC_BITS = cnr_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cnr_pkg::WORD_W-1:0]     in_start_guess,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cnr_pkg::WORD_W-1:0]     out_root,
  output cnr_pkg::status_t                      out_status,
  output logic [cnr_pkg::ITER_W-1:0]            out_iterations_used,
  input  logic                                  cfg_we,
  input  cnr_pkg::cfg_idx_t                     cfg_index,
  input  logic [cnr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import cnr_pkg::*;

  localparam int QUO_W = WORD_W + FRAC_BITS + 1;
  localparam int PC_W  = 4;
  localparam logic signed [WORD_W-1:0] ONE =
    {{(WORD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [PC_W-1:0] OP_XX     = 4'd0;
  localparam logic [PC_W-1:0] OP_X2X    = 4'd1;
  localparam logic [PC_W-1:0] OP_F_CUBE = 4'd2;
  localparam logic [PC_W-1:0] OP_F_SQ   = 4'd3;
  localparam logic [PC_W-1:0] OP_F_LIN  = 4'd4;
  localparam logic [PC_W-1:0] OP_F_CON  = 4'd5;
  localparam logic [PC_W-1:0] OP_D_CUBE = 4'd6;
  localparam logic [PC_W-1:0] OP_D_SQ   = 4'd7;
  localparam logic [PC_W-1:0] OP_D_LIN  = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_EVD, S_CHK, S_DIV, S_UPD, S_DONE
  } state_t;

  state_t state_r;

  logic signed [COEFF_W-1:0] c3_r, c2_r, c1_r, c0_r;
  logic [TOL_W-1:0]          tol_r;
  logic [ITER_W-1:0]         max_it_r;

  logic signed [WORD_W-1:0] x_r, xprev_r, start_r, x2_r, x3_r, f_r, dv_r;
  logic [ITER_W-1:0]        left_r, steps_r;
  logic                     first_r;
  logic [PC_W-1:0]          pc_r;
  logic signed [WORD_W-1:0] out_root_r;
  status_t                  out_status_r;
  logic [ITER_W-1:0]        out_iter_r;

  logic signed [WORD_W-1:0] c3x, c2x, c1x, c0x, c3x3, c2x2;
  logic signed [WORD_W-1:0] op_a, op_b, mac_rnd, mac_acc;
  mac_ctl_t                 mac_ctl;
  logic                     div_start, div_done;
  logic signed [QUO_W-1:0]  quo;

  logic signed [WORD_W:0]   step_diff;
  logic [WORD_W:0]          step_abs, f_abs, d_max;
  logic                     conv, go_div;
  logic signed [PROD_W-1:0] x_ext, q_ext;
  logic signed [WORD_W-1:0] x1_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r     <= 16'sd1;
      c2_r     <= 16'sd0;
      c1_r     <= -16'sd9;
      c0_r     <= 16'sd6;
      tol_r    <= 16'd1;
      max_it_r <= 8'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUBE:     c3_r     <= cfg_data;
        REG_SQUARE:   c2_r     <= cfg_data;
        REG_LINEAR:   c1_r     <= cfg_data;
        REG_CONST:    c0_r     <= cfg_data;
        REG_TOL:      tol_r    <= cfg_data;
        REG_MAX_ITER: max_it_r <= cfg_data[ITER_W-1:0];
        default:      ;
      endcase
    end
  end

  assign c3x  = {{(WORD_W-COEFF_W){c3_r[COEFF_W-1]}}, c3_r};
  assign c2x  = {{(WORD_W-COEFF_W){c2_r[COEFF_W-1]}}, c2_r};
  assign c1x  = {{(WORD_W-COEFF_W){c1_r[COEFF_W-1]}}, c1_r};
  assign c0x  = {{(WORD_W-COEFF_W){c0_r[COEFF_W-1]}}, c0_r};
  assign c3x3 = c3x + (c3x <<< 1);
  assign c2x2 = c2x <<< 1;

  // operand select per micro-op
  always_comb begin
    case (pc_r)
      OP_XX:     begin op_a = x_r;  op_b = x_r;  end
      OP_X2X:    begin op_a = x2_r; op_b = x_r;  end
      OP_F_CUBE: begin op_a = c3x;  op_b = x3_r; end
      OP_F_SQ:   begin op_a = c2x;  op_b = x2_r; end
      OP_F_LIN:  begin op_a = c1x;  op_b = x_r;  end
      OP_F_CON:  begin op_a = c0x;  op_b = ONE;  end
      OP_D_CUBE: begin op_a = c3x3; op_b = x2_r; end
      OP_D_SQ:   begin op_a = c2x2; op_b = x_r;  end
      OP_D_LIN:  begin op_a = c1x;  op_b = ONE;  end
      default:   begin op_a = '0;   op_b = '0;   end
    endcase
  end

  assign mac_ctl.mul_en  = (state_r == S_MUL);
  assign mac_ctl.acc_en  = (state_r == S_ACC) && (pc_r != OP_XX) && (pc_r != OP_X2X);
  assign mac_ctl.acc_clr = (pc_r == OP_F_CUBE) || (pc_r == OP_D_CUBE);

  cnr_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .rnd     (mac_rnd),
    .acc_sat (mac_acc)
  );

  // stop tests
  assign step_diff = {x_r[WORD_W-1], x_r} - {xprev_r[WORD_W-1], xprev_r};
  assign step_abs  = step_diff[WORD_W] ? (~step_diff + 1'b1) : step_diff;
  assign f_abs     = f_r[WORD_W-1] ? (~{1'b1, f_r} + 1'b1) : {1'b0, f_r};
  assign d_max     = (f_abs > step_abs) ? f_abs : step_abs;
  assign conv      = !first_r && (d_max < {{(WORD_W+1-TOL_W){1'b0}}, tol_r});
  assign go_div    = !conv && (left_r != '0) && (dv_r != '0);
  assign div_start = (state_r == S_CHK) && go_div;

  cnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (f_r),
    .den   (dv_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign x_ext  = {{(PROD_W-WORD_W){x_r[WORD_W-1]}}, x_r};
  assign q_ext  = {{(PROD_W-QUO_W){quo[QUO_W-1]}}, quo};
  assign x1_nxt = sat_word(x_ext - q_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            start_r <= in_start_guess;
            x_r     <= in_start_guess;
            xprev_r <= in_start_guess;
            left_r  <= max_it_r;
            steps_r <= '0;
            first_r <= 1'b1;
            pc_r    <= OP_XX;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (pc_r == OP_D_CUBE) begin
            f_r <= mac_acc;
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (pc_r == OP_XX) begin
            x2_r <= mac_rnd;
          end
          if (pc_r == OP_X2X) begin
            x3_r <= mac_rnd;
          end
          if (pc_r == OP_D_LIN) begin
            state_r <= S_EVD;
          end else begin
            pc_r    <= pc_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_EVD: begin
          dv_r    <= mac_acc;
          state_r <= S_CHK;
        end
        S_CHK: begin
          out_iter_r <= steps_r;
          if (conv) begin
            out_root_r   <= x_r;
            out_status_r <= ST_CONVERGED;
            state_r      <= S_DONE;
          end else if (left_r == '0) begin
            out_root_r   <= x_r;
            out_status_r <= ST_CAP;
            state_r      <= S_DONE;
          end else if (dv_r == '0) begin
            out_root_r   <= start_r;
            out_status_r <= ST_ZERO_DERIV;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          xprev_r <= x_r;
          x_r     <= x1_nxt;
          steps_r <= steps_r + 1'b1;
          left_r  <= left_r - 1'b1;
          first_r <= 1'b0;
          pc_r    <= OP_XX;
          state_r <= S_MUL;
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_root            = out_root_r;
  assign out_status          = out_status_r;
  assign out_iterations_used = out_iter_r;

  `CNR_ASSERT_IMP(a_zero_deriv_root, out_valid && out_status == ST_ZERO_DERIV, out_root == start_r)
  `CNR_ASSERT_IMP(a_conv_steps, out_valid && out_status == ST_CONVERGED, out_iterations_used != '0)
  `CNR_ASSERT_IMP(a_div_done_state, div_done, state_r == S_DIV)
  `CNR_ASSERT_NXT(a_upd_restarts_eval, state_r == S_UPD, state_r == S_MUL && pc_r == OP_XX)

endmodule
